// ===== design/okvt_pkg.sv =====
// Shared types, codes and default sizes for the ordered key/value table.
package okvt_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int KEY_W_DEF = 32;
    localparam int VAL_W_DEF = 32;

    typedef enum logic [2:0] {
        MODE_INSERT = 3'd0,
        MODE_UPDATE = 3'd1,
        MODE_UPSERT = 3'd2,
        MODE_ERASE  = 3'd3,
        MODE_LOOKUP = 3'd4,
        MODE_READ   = 3'd5
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_MISS  = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CS_IDLE   = 2'd0,
        CS_SEARCH = 2'd1,
        CS_EXEC   = 2'd2
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // capture the request fields
        logic search;  // compare the key against every stored entry
        logic exec;    // apply the operation and load the result register
    } cmd_t;

endpackage

// ===== design/okvt_ctrl.sv =====
// Controller state machine for the ordered key/value table.
module okvt_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    output okvt_pkg::cmd_t cmd
);
    import okvt_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= CS_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            CS_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = CS_SEARCH;
                end
            end
            CS_SEARCH:
            begin
                cmd.search = 1'b1;
                state_next = CS_EXEC;
            end
            CS_EXEC:
            begin
                // The result can only be written once the output slot is free;
                // the next request is taken in the same cycle.
                if (out_free)
                begin
                    cmd.exec = 1'b1;
                    in_ready = 1'b1;
                    if (in_valid)
                    begin
                        cmd.load   = 1'b1;
                        state_next = CS_SEARCH;
                    end
                    else
                    begin
                        state_next = CS_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = CS_IDLE;
            end
        endcase
        out_valid_next = cmd.exec || (out_valid_reg && !out_ready);
    end

endmodule

// ===== design/okvt_dp.sv =====
// Datapath of the ordered key/value table: entry storage, key match and operations.
module okvt_dp #(
    parameter int DEPTH = okvt_pkg::DEPTH_DEF,
    parameter int KEY_W = okvt_pkg::KEY_W_DEF,
    parameter int VAL_W = okvt_pkg::VAL_W_DEF,
    parameter int POS_W = $clog2(DEPTH),
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  okvt_pkg::cmd_t   cmd,
    input  logic [2:0]       mode,
    input  logic [KEY_W-1:0] key,
    input  logic [VAL_W-1:0] value,
    input  logic [POS_W-1:0] position,
    output logic [1:0]       status,
    output logic [KEY_W-1:0] out_key,
    output logic [VAL_W-1:0] out_value,
    output logic [CNT_W-1:0] entry_count
);
    import okvt_pkg::*;

    mode_t            mode_reg;
    logic [KEY_W-1:0] key_reg;
    logic [VAL_W-1:0] value_reg;
    logic [POS_W-1:0] pos_reg;

    logic [KEY_W-1:0] key_mem_reg [DEPTH];
    logic [VAL_W-1:0] val_mem_reg [DEPTH];
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [DEPTH-1:0] hit_reg;
    logic [DEPTH-1:0] hit_next;

    status_t          status_reg;
    status_t          status_next;
    logic [KEY_W-1:0] out_key_reg;
    logic [KEY_W-1:0] out_key_next;
    logic [VAL_W-1:0] out_value_reg;
    logic [VAL_W-1:0] out_value_next;

    logic [POS_W-1:0] slot;
    logic [POS_W-1:0] rd_idx;
    logic             found;
    logic             full;
    logic             pos_ok;
    logic             do_append;
    logic             do_write;
    logic             do_erase;

    // Request capture.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg  <= mode_t'(mode);
            key_reg   <= key;
            value_reg <= value;
            pos_reg   <= position;
        end
    end

    // Associative match against the occupied entries.
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            hit_next[i] = (key_mem_reg[i] == key_reg) && (CNT_W'(i) < count_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.search)
        begin
            hit_reg <= hit_next;
        end
    end

    // Keys are unique, so at most one hit bit is set and an OR encodes it.
    always_comb
    begin
        slot = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (hit_reg[i])
            begin
                slot = slot | POS_W'(i);
            end
        end
    end

    assign found  = |hit_reg;
    assign full   = (count_reg == CNT_W'(DEPTH));
    assign pos_ok = (CNT_W'(pos_reg) < count_reg);
    assign rd_idx = (mode_reg == MODE_READ) ? pos_reg : slot;

    always_comb
    begin
        status_next    = ST_OK;
        out_key_next   = '0;
        out_value_next = '0;
        do_append      = 1'b0;
        do_write       = 1'b0;
        do_erase       = 1'b0;
        case (mode_reg)
            MODE_INSERT:
            begin
                if (found)
                    status_next = ST_MISS;
                else if (full)
                    status_next = ST_FULL;
                else
                    do_append = 1'b1;
            end
            MODE_UPDATE:
            begin
                if (found)
                    do_write = 1'b1;
                else
                    status_next = ST_MISS;
            end
            MODE_UPSERT:
            begin
                if (found)
                    do_write = 1'b1;
                else if (full)
                    status_next = ST_FULL;
                else
                    do_append = 1'b1;
            end
            MODE_ERASE:
            begin
                if (found)
                    do_erase = 1'b1;
                else
                    status_next = ST_MISS;
            end
            MODE_LOOKUP:
            begin
                if (found)
                    out_value_next = val_mem_reg[rd_idx];
                else
                    status_next = ST_MISS;
            end
            MODE_READ:
            begin
                if (pos_ok)
                begin
                    out_key_next   = key_mem_reg[rd_idx];
                    out_value_next = val_mem_reg[rd_idx];
                end
                else
                begin
                    status_next = ST_RANGE;
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase

        count_next = count_reg;
        if (do_append)
            count_next = count_reg + CNT_W'(1);
        else if (do_erase)
            count_next = count_reg - CNT_W'(1);
    end

    // Entry storage: append at the tail, overwrite in place, or close the gap
    // left by an erase by moving every later entry down one place.
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                if (do_erase && (i < DEPTH - 1) && (POS_W'(i) >= slot))
                begin
                    key_mem_reg[i] <= key_mem_reg[(i + 1) % DEPTH];
                    val_mem_reg[i] <= val_mem_reg[(i + 1) % DEPTH];
                end
                else if (do_append && (count_reg[POS_W-1:0] == POS_W'(i)))
                begin
                    key_mem_reg[i] <= key_reg;
                    val_mem_reg[i] <= value_reg;
                end
                else if (do_write && hit_reg[i])
                begin
                    val_mem_reg[i] <= value_reg;
                end
            end
            status_reg    <= status_next;
            out_key_reg   <= out_key_next;
            out_value_reg <= out_value_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.exec)
        begin
            count_reg <= count_next;
        end
    end

    assign status      = status_reg;
    assign out_key     = out_key_reg;
    assign out_value   = out_value_reg;
    // The count only moves when a new result is written, so it always
    // matches the result that is on offer.
    assign entry_count = count_reg;

endmodule

// ===== design/ordered_key_value_table_top.sv =====
// Top level of the ordered key/value table: controller, datapath and checks.
//
//   Channel | Handshake            | Payload
//   --------+----------------------+------------------------------------------
//   request | in_valid / in_ready  | mode, key, value, position
//   result  | out_valid / out_ready| status, out_key, out_value, entry_count
//
// Each request passes through SEARCH, which compares the key against every stored
// entry and registers the match vector, and EXEC, which applies the operation and
// loads the result register. The next request is taken in EXEC, never in SEARCH.
// A result waits in its output register; a new request is still taken while it
// waits, but that request's EXEC step holds until the output slot is free.
// Reset empties the table at once: only the entry count and control state are
// cleared, and no entry is ever read beyond the count.
module ordered_key_value_table_top #(
    parameter int DEPTH = okvt_pkg::DEPTH_DEF,
    parameter int KEY_W = okvt_pkg::KEY_W_DEF,
    parameter int VAL_W = okvt_pkg::VAL_W_DEF,
    parameter int POS_W = $clog2(DEPTH),
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [2:0]       mode,
    input  logic [KEY_W-1:0] key,
    input  logic [VAL_W-1:0] value,
    input  logic [POS_W-1:0] position,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [1:0]       status,
    output logic [KEY_W-1:0] out_key,
    output logic [VAL_W-1:0] out_value,
    output logic [CNT_W-1:0] entry_count
);
    import okvt_pkg::*;

    cmd_t cmd;

    // The controller sequences each request and owns both handshakes.
    okvt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    // The datapath holds the entries, performs the match and the operation,
    // and keeps the result register.
    okvt_dp #(
        .DEPTH (DEPTH),
        .KEY_W (KEY_W),
        .VAL_W (VAL_W),
        .POS_W (POS_W),
        .CNT_W (CNT_W)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .mode        (mode),
        .key         (key),
        .value       (value),
        .position    (position),
        .status      (status),
        .out_key     (out_key),
        .out_value   (out_value),
        .entry_count (entry_count)
    );

`ifndef SYNTH
    // The table never reports more entries than it can hold.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (entry_count <= CNT_W'(DEPTH)))
        else $error("entry count exceeds table depth");

    // A full status is only reported by a table that is actually full.
    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == ST_FULL)) |-> (entry_count == CNT_W'(DEPTH)))
        else $error("full status with free entries");

    // An out-of-range read returns no data.
    a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == ST_RANGE)) |-> ((out_key == '0) && (out_value == '0)))
        else $error("out-of-range read returned data");
`endif

endmodule
